### sv/urbs_pkg.sv
// Shared types and constants for the UART receive bit sampler.
package urbs_pkg;

    // Receiver phase codes.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_DATA = 2'd1;
    localparam logic [1:0] PH_STOP = 2'd2;

    // Field widths and fixed limits.
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LIMIT_W = 3;

    localparam logic [BYTE_W-1:0]  IDLE_MAX    = 8'hFF;
    localparam logic [LIMIT_W-1:0] STOP_MAX    = 3'd7;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 3'd3;

    typedef logic [1:0] t_phase;

    // One result beat.
    typedef struct packed {
        logic              byte_valid;
        logic [BYTE_W-1:0] rx_byte;
        logic              frame_error;
        logic              idle_pulse;
        logic [BYTE_W-1:0] idle_count;
        logic              edge_rearm;
    } t_result;

endpackage

### sv/urbs_step.sv
// Next-state and result logic for one sample beat of the receiver.
module urbs_step #(
    parameter int unsigned DATA_BITS = 8,
    parameter int unsigned CNT_W     = 4
) (
    input  logic                          i_operation,
    input  logic                          i_line_level,
    input  logic [urbs_pkg::LIMIT_W-1:0]  i_limit,
    input  urbs_pkg::t_phase              i_phase,
    input  logic [CNT_W-1:0]              i_bits,
    input  logic [urbs_pkg::BYTE_W-1:0]   i_shift,
    input  logic [urbs_pkg::LIMIT_W-1:0]  i_stop,
    input  logic [urbs_pkg::BYTE_W-1:0]   i_idle,
    output urbs_pkg::t_phase              o_phase,
    output logic [CNT_W-1:0]              o_bits,
    output logic [urbs_pkg::BYTE_W-1:0]   o_shift,
    output logic [urbs_pkg::LIMIT_W-1:0]  o_stop,
    output logic [urbs_pkg::BYTE_W-1:0]   o_idle,
    output urbs_pkg::t_result             o_result
);
    import urbs_pkg::*;

    logic [CNT_W-1:0]   bits_inc;
    logic [LIMIT_W-1:0] stop_inc;

    assign bits_inc = i_bits + 1'b1;
    assign stop_inc = (i_stop < STOP_MAX) ? i_stop + 1'b1 : i_stop;

    // Phase update and flags for the current beat.
    always_comb begin
        o_phase  = i_phase;
        o_bits   = i_bits;
        o_shift  = i_shift;
        o_stop   = i_stop;
        o_idle   = i_idle;
        o_result = '0;

        if (i_operation) begin
            // A start edge restarts reception in any phase.
            o_phase = PH_DATA;
            o_bits  = '0;
            o_shift = '0;
            o_stop  = '0;
            o_idle  = '0;
        end else begin
            case (i_phase)
                PH_IDLE: begin
                    if (!i_line_level) begin
                        o_phase = PH_DATA;
                        o_bits  = '0;
                        o_shift = '0;
                        o_stop  = '0;
                        o_idle  = '0;
                    end else begin
                        if (i_idle < IDLE_MAX) begin
                            o_idle = i_idle + 1'b1;
                        end
                        o_result.idle_pulse = 1'b1;
                    end
                end
                PH_DATA: begin
                    // Bits past the byte width are counted but not kept.
                    if (int'(i_bits) < int'(BYTE_W)) begin
                        o_shift[i_bits[2:0]] = i_line_level;
                    end
                    o_bits = bits_inc;
                    if (bits_inc >= CNT_W'(DATA_BITS)) begin
                        o_result.edge_rearm = 1'b1;
                        o_phase             = PH_STOP;
                        o_stop              = '0;
                    end
                end
                PH_STOP: begin
                    o_stop = stop_inc;
                    if (i_line_level) begin
                        o_result.byte_valid = 1'b1;
                        o_result.rx_byte    = i_shift;
                        o_phase             = PH_IDLE;
                        o_bits              = '0;
                        o_idle              = '0;
                    end else if (stop_inc >= i_limit) begin
                        o_result.frame_error = 1'b1;
                        o_phase              = PH_IDLE;
                        o_bits               = '0;
                        o_idle               = '0;
                    end
                end
                default: begin
                    o_phase = PH_IDLE;
                end
            endcase
        end

        o_result.idle_count = o_idle;
    end

endmodule

### sv/uart_rx_bit_sampler.sv
// Top level of the UART receive bit sampler.
// Each input beat is one bit-period sample of the receive line or a start-edge
// event, and produces exactly one result beat, valid the cycle after acceptance.
// A beat can be accepted on every clock: the next receiver state is combinational
// and the result is held in an output register, so the input stays ready
// while a result waits unless that register is full and not being drained.
// The stop-wait limit may only be written while no beat is in flight.
module uart_rx_bit_sampler #(
    parameter int unsigned DATA_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Sample beat input
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_operation,
    input  logic                          i_line_level,
    // Configuration write
    input  logic                          i_cfg_wr_en,
    input  logic [urbs_pkg::LIMIT_W-1:0]  i_cfg_wr_data,
    // Result beat output
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_byte_valid,
    output logic [urbs_pkg::BYTE_W-1:0]   o_rx_byte,
    output logic                          o_frame_error,
    output logic                          o_idle_pulse,
    output logic [urbs_pkg::BYTE_W-1:0]   o_idle_count,
    output logic                          o_edge_rearm
);
    import urbs_pkg::*;

    localparam int unsigned CNT_W = $clog2(DATA_BITS + 1);

    t_phase             r_phase, n_phase;
    logic [CNT_W-1:0]   r_bits, n_bits;
    logic [BYTE_W-1:0]  r_shift, n_shift;
    logic [LIMIT_W-1:0] r_stop, n_stop;
    logic [BYTE_W-1:0]  r_idle, n_idle;
    logic [LIMIT_W-1:0] r_limit;
    t_result            r_out, n_out;
    logic               r_out_valid;
    logic               accept;

    // The output register can take a new beat when empty or being drained.
    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    urbs_step #(
        .DATA_BITS (DATA_BITS),
        .CNT_W     (CNT_W)
    ) u_step (
        .i_operation  (i_operation),
        .i_line_level (i_line_level),
        .i_limit      (r_limit),
        .i_phase      (r_phase),
        .i_bits       (r_bits),
        .i_shift      (r_shift),
        .i_stop       (r_stop),
        .i_idle       (r_idle),
        .o_phase      (n_phase),
        .o_bits       (n_bits),
        .o_shift      (n_shift),
        .o_stop       (n_stop),
        .o_idle       (n_idle),
        .o_result     (n_out)
    );

    // Receiver state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bits  <= '0;
            r_shift <= '0;
            r_stop  <= '0;
            r_idle  <= '0;
            r_limit <= LIMIT_RESET;
        end else begin
            if (accept) begin
                r_phase <= n_phase;
                r_bits  <= n_bits;
                r_shift <= n_shift;
                r_stop  <= n_stop;
                r_idle  <= n_idle;
            end
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_ready) begin
            r_out_valid <= i_valid;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_byte_valid  = r_out.byte_valid;
    assign o_rx_byte     = r_out.rx_byte;
    assign o_frame_error = r_out.frame_error;
    assign o_idle_pulse  = r_out.idle_pulse;
    assign o_idle_count  = r_out.idle_count;
    assign o_edge_rearm  = r_out.edge_rearm;

endmodule
